// ----- hdl/clt_pkg.sv -----
package clt_pkg;

   localparam int CAPACITY = 64;
   localparam int POS_W    = 6;
   localparam int CNT_W    = 7;
   localparam int DATA_W   = 32;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_LIST   = 2'd2;
   localparam logic [1:0] REQ_SEARCH = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_ENTRY     = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef enum logic [2:0] {
      RES_OK,
      RES_FULL,
      RES_NOT_FOUND,
      RES_FOUND,
      RES_ENTRY,
      RES_EMPTY
   } res_kind_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_INC
   } idx_op_type;

   typedef struct packed {
      logic         accept;
      idx_op_type   idx_op;
      logic         save_pos;
      logic         wr_insert;
      logic         wr_shift;
      logic         cnt_dec;
      logic         out_load;
      res_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic full;
      logic empty;
      logic scan_end;
      logic hit;
      logic list_last;
   } sts_type;

endpackage

// ----- hdl/clt_req_if.sv -----
interface clt_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       req_type;
   logic signed [clt_pkg::DATA_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ----- hdl/clt_rsp_if.sv -----
interface clt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [2:0]                        status;
   logic [clt_pkg::POS_W-1:0]         position;
   logic signed [clt_pkg::DATA_W-1:0] item_value;
   logic                              last;

   modport source (output valid, output status, output position, output item_value,
                   output last, input ready);
   modport sink   (input valid, input status, input position, input item_value,
                   input last, output ready);
endinterface

// ----- hdl/clt_ctrl.sv -----
module clt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_type,
   output logic              req_ready,
   input  clt_pkg::sts_type  sts,
   output clt_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_SCAN,
      S_SHIFT,
      S_LIST,
      S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            type_ff, type_in;
   clt_pkg::res_kind_type res_ff, res_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      res_in       = res_ff;
      cmd          = '0;
      cmd.idx_op   = clt_pkg::IDX_HOLD;
      cmd.out_kind = clt_pkg::RES_OK;
      case (state_ff)
         S_IDLE: begin
            cmd.idx_op = clt_pkg::IDX_ZERO;
            if (req_valid) begin
               cmd.accept = 1'b1;
               type_in    = req_type;
               case (req_type)
                  clt_pkg::REQ_INSERT: state_in = S_INSERT;
                  clt_pkg::REQ_LIST:   state_in = S_LIST;
                  default:             state_in = S_SCAN;
               endcase
            end
         end
         S_INSERT: begin
            if (sts.full) begin
               res_in = clt_pkg::RES_FULL;
            end else begin
               cmd.wr_insert = 1'b1;
               res_in        = clt_pkg::RES_OK;
            end
            state_in = S_EMIT;
         end
         S_SCAN: begin
            if (sts.scan_end) begin
               res_in   = clt_pkg::RES_NOT_FOUND;
               state_in = S_EMIT;
            end else if (sts.hit) begin
               cmd.save_pos = 1'b1;
               if (type_ff == clt_pkg::REQ_REMOVE) begin
                  cmd.idx_op = clt_pkg::IDX_INC;
                  state_in   = S_SHIFT;
               end else begin
                  res_in   = clt_pkg::RES_FOUND;
                  state_in = S_EMIT;
               end
            end else begin
               cmd.idx_op = clt_pkg::IDX_INC;
            end
         end
         S_SHIFT: begin
            // Each later entry moves down one place; the read runs one ahead of the write.
            if (sts.scan_end) begin
               cmd.cnt_dec = 1'b1;
               res_in      = clt_pkg::RES_FOUND;
               state_in    = S_EMIT;
            end else begin
               cmd.wr_shift = 1'b1;
               cmd.idx_op   = clt_pkg::IDX_INC;
            end
         end
         S_LIST: begin
            if (sts.empty) begin
               res_in   = clt_pkg::RES_EMPTY;
               state_in = S_EMIT;
            end else if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = clt_pkg::RES_ENTRY;
               if (sts.list_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_op = clt_pkg::IDX_INC;
               end
            end
         end
         S_EMIT: begin
            cmd.out_kind = res_ff;
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         type_ff  <= clt_pkg::REQ_INSERT;
         res_ff   <= clt_pkg::RES_OK;
      end else begin
         state_ff <= state_in;
         type_ff  <= type_in;
         res_ff   <= res_in;
      end
   end

endmodule

// ----- hdl/clt_datapath.sv -----
module clt_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  clt_pkg::cmd_type                  cmd,
   output clt_pkg::sts_type                  sts,
   input  logic signed [clt_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [clt_pkg::POS_W-1:0]         rsp_position,
   output logic signed [clt_pkg::DATA_W-1:0] rsp_item_value,
   output logic                              rsp_last
);

   logic [clt_pkg::DATA_W-1:0] mem [clt_pkg::CAPACITY];

   logic [clt_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [clt_pkg::CNT_W-1:0]         idx_ff, idx_in;
   logic [clt_pkg::CNT_W-1:0]         idx_m1;
   logic [clt_pkg::CNT_W-1:0]         idx_p1;
   logic [clt_pkg::POS_W-1:0]         pos_ff;
   logic signed [clt_pkg::DATA_W-1:0] value_ff;
   logic [clt_pkg::DATA_W-1:0]        rd_data_ff;

   logic                              out_valid_ff;
   logic [2:0]                        status_ff, status_in;
   logic [clt_pkg::POS_W-1:0]         position_ff, position_in;
   logic signed [clt_pkg::DATA_W-1:0] item_value_ff, item_value_in;
   logic                              last_ff, last_in;

   assign idx_m1 = idx_ff - clt_pkg::CNT_W'(1);
   assign idx_p1 = idx_ff + clt_pkg::CNT_W'(1);

   always_comb begin
      case (cmd.idx_op)
         clt_pkg::IDX_ZERO: idx_in = '0;
         clt_pkg::IDX_INC:  idx_in = idx_p1;
         default:           idx_in = idx_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.wr_insert) begin
         count_in = count_ff + clt_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - clt_pkg::CNT_W'(1);
      end
   end

   // The read address follows the next index, so the read data always matches idx_ff.
   always_ff @(posedge clock) begin
      if (cmd.wr_insert) begin
         mem[count_ff[clt_pkg::POS_W-1:0]] <= value_ff;
      end else if (cmd.wr_shift) begin
         mem[idx_m1[clt_pkg::POS_W-1:0]] <= rd_data_ff;
      end
      rd_data_ff <= mem[idx_in[clt_pkg::POS_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         value_ff <= req_value;
      end
      if (cmd.save_pos) begin
         pos_ff <= idx_ff[clt_pkg::POS_W-1:0];
      end
   end

   always_comb begin
      status_in     = clt_pkg::ST_OK;
      position_in   = '0;
      item_value_in = '0;
      last_in       = 1'b1;
      case (cmd.out_kind)
         clt_pkg::RES_FULL:      status_in = clt_pkg::ST_FULL;
         clt_pkg::RES_NOT_FOUND: status_in = clt_pkg::ST_NOT_FOUND;
         clt_pkg::RES_EMPTY:     status_in = clt_pkg::ST_EMPTY;
         clt_pkg::RES_FOUND: begin
            position_in   = pos_ff;
            item_value_in = value_ff;
         end
         clt_pkg::RES_ENTRY: begin
            status_in     = clt_pkg::ST_ENTRY;
            position_in   = idx_ff[clt_pkg::POS_W-1:0];
            item_value_in = rd_data_ff;
            last_in       = sts.list_last;
         end
         default: status_in = clt_pkg::ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         status_ff     <= status_in;
         position_ff   <= position_in;
         item_value_ff <= item_value_in;
         last_ff       <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.slot_free = !out_valid_ff || rsp_ready;
   assign sts.full      = (count_ff == clt_pkg::CNT_W'(clt_pkg::CAPACITY));
   assign sts.empty     = (count_ff == '0);
   assign sts.scan_end  = (idx_ff >= count_ff);
   assign sts.hit       = (rd_data_ff == value_ff);
   assign sts.list_last = (idx_p1 == count_ff);

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_position   = position_ff;
   assign rsp_item_value = item_value_ff;
   assign rsp_last       = last_ff;

endmodule

// ----- hdl/compacting_list_table.sv -----
// Insert goes through its insert and emit states before the result is registered; search
// compares one stored entry per cycle through the single memory read port.
// Remove scans and then moves every later entry down, one entry per cycle.
// List delivers one entry per cycle while the sink takes them.
// One request is in progress at a time; the next is taken once the last result is registered.
// Synchronous reset empties the list and clears control; stored words are left as they are.
module compacting_list_table (
   input  logic    clock,
   input  logic    reset,
   clt_req_if.sink   req_if,
   clt_rsp_if.source rsp_if
);

   clt_pkg::cmd_type cmd;
   clt_pkg::sts_type sts;

   clt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   clt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_value      (req_if.value),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_status     (rsp_if.status),
      .rsp_position   (rsp_if.position),
      .rsp_item_value (rsp_if.item_value),
      .rsp_last       (rsp_if.last)
   );

endmodule

// ----- sim/tb_compacting_list_table.sv -----
`timescale 1ns / 1ps

module tb_compacting_list_table;

   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_ITEMS  = 25;
   localparam int DRAIN_WAIT  = 80;

   typedef struct {
      logic [1:0]                        req_type;
      logic signed [clt_pkg::DATA_W-1:0] value;
      bit                                drain;
   } request_type;

   typedef struct packed {
      logic [2:0]                        status;
      logic [clt_pkg::POS_W-1:0]         position;
      logic signed [clt_pkg::DATA_W-1:0] item_value;
      logic                              last;
   } list_result_type;

   logic clock;
   logic reset;

   clt_req_if req_if ();
   clt_rsp_if rsp_if ();

   compacting_list_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   request_type                       pending_requests[$];
   list_result_type                   expected_results[$];
   logic signed [clt_pkg::DATA_W-1:0] stored_words[$];

   request_type current_req;
   bit          req_presented;
   int          req_gap;
   bit          quiet_tail;

   int rsp_stall;
   int rsp_hold;
   bit rsp_hold_done;
   int rsp_seen;

   int idle_cycles;
   int mismatches;
   int results_checked;
   int op_count[4];
   int full_refusals;
   int search_hits;
   int search_misses;
   int longest_listing;

   logic signed [clt_pkg::DATA_W-1:0] value_pool[8] = '{
      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1,
      32'sh0000_0001, 32'sh55AA_55AA, 32'shAA55_AA55, 32'sh0001_0000
   };

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic note_mismatch(input string what, input list_result_type want,
                                input list_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%t: %s: expected status %0d pos %0d value %0d last %0b,",
                  $realtime, what, want.status, want.position, want.item_value, want.last);
         $display("   got status %0d pos %0d value %0d last %0b",
                  got.status, got.position, got.item_value, got.last);
      end
   endtask

   task automatic push_result(input logic [2:0] status, input int pos,
                              input logic signed [clt_pkg::DATA_W-1:0] word,
                              input logic last);
      list_result_type r;
      r.status     = status;
      r.position   = clt_pkg::POS_W'(pos);
      r.item_value = word;
      r.last       = last;
      expected_results.push_back(r);
   endtask

   // Updates the shadow list for one accepted request and queues its results.
   task automatic apply_request(input request_type rq);
      int hit;
      int n;
      hit = -1;
      n   = stored_words.size();
      op_count[rq.req_type]++;
      case (rq.req_type)
         clt_pkg::REQ_INSERT: begin
            if (n < clt_pkg::CAPACITY) begin
               stored_words.push_back(rq.value);
               push_result(clt_pkg::ST_OK, 0, '0, 1'b1);
            end else begin
               full_refusals++;
               push_result(clt_pkg::ST_FULL, 0, '0, 1'b1);
            end
         end
         clt_pkg::REQ_LIST: begin
            if (n == 0) begin
               push_result(clt_pkg::ST_EMPTY, 0, '0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++)
                  push_result(clt_pkg::ST_ENTRY, i, stored_words[i], i == n - 1);
               if (n > longest_listing) longest_listing = n;
            end
         end
         default: begin
            for (int i = 0; i < n && hit < 0; i++)
               if (stored_words[i] === rq.value) hit = i;
            if (hit < 0) begin
               search_misses++;
               push_result(clt_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
            end else begin
               search_hits++;
               push_result(clt_pkg::ST_OK, hit, rq.value, 1'b1);
               if (rq.req_type == clt_pkg::REQ_REMOVE) stored_words.delete(hit);
            end
         end
      endcase
   endtask

   task automatic add_request(input logic [1:0] kind,
                              input logic signed [clt_pkg::DATA_W-1:0] word,
                              input bit drain = 1'b0);
      request_type rq;
      rq.req_type = kind;
      rq.value    = word;
      rq.drain    = drain;
      pending_requests.push_back(rq);
   endtask

   // Half of the words come from a small pool so that duplicates and hits are common.
   function automatic logic signed [clt_pkg::DATA_W-1:0] pick_word();
      if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return clt_pkg::REQ_INSERT;
      if (roll < 60) return clt_pkg::REQ_REMOVE;
      if (roll < 85) return clt_pkg::REQ_SEARCH;
      return clt_pkg::REQ_LIST;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            apply_request(current_req);
            req_presented = 1'b0;
            if (!quiet_tail && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 19);
         end
         if (!req_presented) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_requests.size() != 0 &&
                         (!pending_requests[0].drain || expected_results.size() == 0)) begin
               current_req   = pending_requests.pop_front();
               req_presented = 1'b1;
            end
         end
         quiet_tail = (pending_requests.size() < TAIL_ITEMS);
         req_if.valid    <= req_presented;
         req_if.req_type <= current_req.req_type;
         req_if.value    <= current_req.value;
      end
   end

   // The receiver holds off once for a long stretch so that the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) rsp_seen++;
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= 1'b0;
         end else if (!rsp_hold_done && rsp_seen >= 30) begin
            rsp_hold_done = 1'b1;
            rsp_hold      = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(0, 18);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status     = rsp_if.status;
         got.position   = rsp_if.position;
         got.item_value = rsp_if.item_value;
         got.last       = rsp_if.last;
         if (expected_results.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (got !== want) note_mismatch("result differs", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.req_type = clt_pkg::REQ_INSERT;
      req_if.value    = '0;
      rsp_if.ready    = 1'b0;
      current_req     = '{clt_pkg::REQ_INSERT, '0, 1'b0};

      // Empty list, boundary words, duplicates and a one-bit near miss.
      add_request(clt_pkg::REQ_LIST,   '0);
      add_request(clt_pkg::REQ_SEARCH, 32'sh0);
      add_request(clt_pkg::REQ_REMOVE, 32'sh0);
      add_request(clt_pkg::REQ_INSERT, 32'sh8000_0000);
      add_request(clt_pkg::REQ_INSERT, 32'sh7FFF_FFFF);
      add_request(clt_pkg::REQ_INSERT, 32'sh0);
      add_request(clt_pkg::REQ_INSERT, -32'sd1);
      add_request(clt_pkg::REQ_INSERT, 32'sh7FFF_FFFF);
      add_request(clt_pkg::REQ_SEARCH, 32'sh7FFF_FFFF);
      add_request(clt_pkg::REQ_SEARCH, -32'sd2);
      add_request(clt_pkg::REQ_SEARCH, 32'sh8000_0000);
      add_request(clt_pkg::REQ_LIST,   32'sh1234_5678);
      add_request(clt_pkg::REQ_REMOVE, 32'sh7FFF_FFFF);
      add_request(clt_pkg::REQ_REMOVE, 32'sh8000_0000);
      add_request(clt_pkg::REQ_REMOVE, 32'sd12345);
      add_request(clt_pkg::REQ_LIST,   '0);
      add_request(clt_pkg::REQ_REMOVE, 32'sh7FFF_FFFF);
      add_request(clt_pkg::REQ_REMOVE, 32'sh0);
      add_request(clt_pkg::REQ_REMOVE, -32'sd1);
      add_request(clt_pkg::REQ_LIST,   '0);
      add_request(clt_pkg::REQ_INSERT, 32'sd1);
      add_request(clt_pkg::REQ_LIST,   -32'sd1);

      for (int i = 0; i < 30; i++) add_request(pick_kind(), pick_word());

      // Fill to capacity after a full drain, then work against a full list.
      add_request(clt_pkg::REQ_INSERT, pick_word(), 1'b1);
      for (int i = 0; i < 65; i++) add_request(clt_pkg::REQ_INSERT, pick_word());
      add_request(clt_pkg::REQ_INSERT, pick_word());
      add_request(clt_pkg::REQ_LIST, pick_word());
      for (int i = 0; i < 3; i++)
         add_request(clt_pkg::REQ_SEARCH, value_pool[$urandom_range(0, 7)]);
      for (int i = 0; i < 3; i++)
         add_request(clt_pkg::REQ_REMOVE, value_pool[$urandom_range(0, 7)]);
      add_request(clt_pkg::REQ_INSERT, pick_word());
      add_request(clt_pkg::REQ_LIST, pick_word());

      for (int i = 0; i < 30; i++) add_request(pick_kind(), pick_word(), i == 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_requests.size() != 0 || req_presented || expected_results.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (expected_results.size() != 0) mismatches++;
      $display("Covered %0d requests (insert %0d, remove %0d, list %0d, search %0d),",
               op_count[clt_pkg::REQ_INSERT] + op_count[clt_pkg::REQ_REMOVE] +
               op_count[clt_pkg::REQ_LIST] + op_count[clt_pkg::REQ_SEARCH],
               op_count[clt_pkg::REQ_INSERT], op_count[clt_pkg::REQ_REMOVE],
               op_count[clt_pkg::REQ_LIST], op_count[clt_pkg::REQ_SEARCH]);
      $display("%0d results checked, refused when full %0d times, %0d hits, %0d misses,",
               results_checked, full_refusals, search_hits, search_misses);
      $display("longest listing %0d entries.", longest_listing);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- compacting_list_table.f -----
hdl/clt_pkg.sv
hdl/clt_req_if.sv
hdl/clt_rsp_if.sv
hdl/clt_ctrl.sv
hdl/clt_datapath.sv
hdl/compacting_list_table.sv
sim/tb_compacting_list_table.sv
